>>> rtl/cca_pkg.sv
// Shared types and constants for the cell colour attribute map.
// Used by the channel interfaces, the controller, the datapath and the divider.
`timescale 1ns / 1ps

package cca_pkg;

   localparam int COORD_W = 12;
   localparam int PIX_W   = 13;
   localparam int COLOR_W = 8;
   localparam int CSR_W   = 12;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CELL_W       = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CELL_H       = 2'd3;

   localparam logic [CSR_W-1:0] RESET_IMAGE_WIDTH  = 12'd320;
   localparam logic [CSR_W-1:0] RESET_IMAGE_HEIGHT = 12'd200;
   localparam logic [CSR_W-1:0] RESET_CELL_W       = 12'd4;
   localparam logic [CSR_W-1:0] RESET_CELL_H       = 12'd8;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   typedef struct packed {
      logic load;
      logic clear_step;
      logic calc;
      logic mem_go;
      logic put;
   } cca_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic div_busy;
   } cca_stat_type;

endpackage

>>> rtl/cca_req_if.sv
// Request channel: valid/ready handshake carrying one map operation.
// Depends on cca_pkg for field widths.
`timescale 1ns / 1ps

interface cca_req_if;
   import cca_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    opcode;
   logic signed [PIX_W-1:0] px;
   logic signed [PIX_W-1:0] py;
   logic [COLOR_W-1:0]      color_in;

   modport source (output valid, output opcode, output px, output py, output color_in,
                   input ready);
   modport sink   (input valid, input opcode, input px, input py, input color_in,
                   output ready);
endinterface

>>> rtl/cca_rsp_if.sv
// Response channel: valid/ready handshake carrying one operation result.
// Depends on cca_pkg for field widths.
`timescale 1ns / 1ps

interface cca_rsp_if;
   import cca_pkg::*;

   logic               valid;
   logic               ready;
   logic [COLOR_W-1:0] color_out;
   logic               found;
   logic               stored;

   modport source (output valid, output color_out, output found, output stored,
                   input ready);
   modport sink   (input valid, input color_out, input found, input stored,
                   output ready);
endinterface

>>> rtl/cca_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on cca_pkg for the operand width.
`timescale 1ns / 1ps

module cca_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [cca_pkg::COORD_W-1:0] dividend,
   input  logic [cca_pkg::COORD_W-1:0] divisor,
   output logic                        busy,
   output logic [cca_pkg::COORD_W-1:0] quotient,
   output logic [cca_pkg::COORD_W-1:0] remainder
);
   import cca_pkg::*;

   localparam int CNT_W = $clog2(COORD_W + 1);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [COORD_W-1:0] quo_ff, quo_in;
   logic [COORD_W-1:0] rem_ff, rem_in;
   logic [COORD_W-1:0] div_ff, div_in;
   logic [COORD_W:0]   shifted;
   logic [COORD_W:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      shifted = {rem_ff, quo_ff[COORD_W-1]};
      trial   = shifted - {1'b0, div_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(COORD_W);
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         // A clear top bit of the trial means the divisor fitted.
         if (!trial[COORD_W]) begin
            rem_in = trial[COORD_W-1:0];
            quo_in = {quo_ff[COORD_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[COORD_W-1:0];
            quo_in = {quo_ff[COORD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
endmodule

>>> rtl/cca_datapath.sv
// Datapath: configuration registers, two cell dividers, range checks, the cell
// memory and the result register. Depends on cca_pkg and cca_divider.
`timescale 1ns / 1ps

module cca_datapath #(
   parameter int COLS = 128,
   parameter int ROWS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cca_pkg::cca_cmd_type          cmd,
   output cca_pkg::cca_stat_type         stat,
   input  logic                          csr_we,
   input  logic [cca_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cca_pkg::CSR_W-1:0]     csr_wdata,
   input  logic                          req_opcode,
   input  logic signed [cca_pkg::PIX_W-1:0] req_px,
   input  logic signed [cca_pkg::PIX_W-1:0] req_py,
   input  logic [cca_pkg::COLOR_W-1:0]   req_color_in,
   output logic [cca_pkg::COLOR_W-1:0]   rsp_color_out,
   output logic                          rsp_found,
   output logic                          rsp_stored
);
   import cca_pkg::*;

   localparam int DEPTH = COLS * ROWS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PW    = 2 * COORD_W + 1;
   localparam int WORD_W = COLOR_W + 1;

   logic [CSR_W-1:0] width_ff, height_ff, cell_w_ff, cell_h_ff;

   logic               op_ff;
   logic               neg_ff;
   logic [COORD_W-1:0] x_ff, y_ff;
   logic [COLOR_W-1:0] color_ff;

   logic [COORD_W-1:0] eff_w, eff_h;
   logic               bx_busy, by_busy;
   logic [COORD_W-1:0] qx, qy, rx, ry;

   logic          ok_ff, ok_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [PW-1:0] lin;
   logic          cap_ok, grid_ok, image_ok;

   logic [AW-1:0]     clr_ff;
   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_ff;
   logic              mem_we;
   logic [AW-1:0]     mem_addr;
   logic [WORD_W-1:0] mem_wdata;

   logic [COLOR_W-1:0] color_out_ff;
   logic               found_ff, stored_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_IMAGE_WIDTH;
         height_ff <= RESET_IMAGE_HEIGHT;
         cell_w_ff <= RESET_CELL_W;
         cell_h_ff <= RESET_CELL_H;
      end else if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
            CSR_CELL_W:       cell_w_ff <= csr_wdata;
            CSR_CELL_H:       cell_h_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // A zero cell size behaves as a size of one.
   assign eff_w = (cell_w_ff == '0) ? COORD_W'(1) : cell_w_ff;
   assign eff_h = (cell_h_ff == '0) ? COORD_W'(1) : cell_h_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_opcode;
         neg_ff   <= req_px[PIX_W-1] | req_py[PIX_W-1];
         x_ff     <= req_px[COORD_W-1:0];
         y_ff     <= req_py[COORD_W-1:0];
         color_ff <= req_color_in;
      end
   end

   cca_divider u_div_x (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.load),
      .dividend  (req_px[COORD_W-1:0]),
      .divisor   (eff_w),
      .busy      (bx_busy),
      .quotient  (qx),
      .remainder (rx)
   );

   cca_divider u_div_y (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.load),
      .dividend  (req_py[COORD_W-1:0]),
      .divisor   (eff_h),
      .busy      (by_busy),
      .quotient  (qy),
      .remainder (ry)
   );

   // The cell lies inside the ceiling-divided grid exactly when its first
   // pixel, the coordinate less the remainder, lies inside the image.
   always_comb begin
      cap_ok   = ({1'b0, qx} < (COORD_W+1)'(COLS)) && ({1'b0, qy} < (COORD_W+1)'(ROWS));
      grid_ok  = ((x_ff - rx) < width_ff) && ((y_ff - ry) < height_ff);
      image_ok = (x_ff < width_ff) && (y_ff < height_ff);
      lin      = PW'(qx) * PW'(ROWS) + PW'(qy);
      addr_in  = lin[AW-1:0];
      if (op_ff == OP_READ) begin
         ok_in = !neg_ff && cap_ok && grid_ok;
      end else begin
         ok_in = !neg_ff && cap_ok && image_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         ok_ff   <= ok_in;
         addr_ff <= addr_in;
      end
   end

   // Clearing pass after reset marks every cell unset.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   assign mem_we    = cmd.clear_step || (cmd.mem_go && (op_ff == OP_WRITE) && ok_ff);
   assign mem_addr  = cmd.clear_step ? clr_ff : addr_ff;
   assign mem_wdata = cmd.clear_step ? '0 : {1'b1, color_ff};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (cmd.mem_go) begin
         rd_ff <= mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.put) begin
         if ((op_ff == OP_READ) && ok_ff && rd_ff[COLOR_W]) begin
            color_out_ff <= rd_ff[COLOR_W-1:0];
            found_ff     <= 1'b1;
         end else begin
            color_out_ff <= '0;
            found_ff     <= 1'b0;
         end
         stored_ff <= (op_ff == OP_WRITE) && ok_ff;
      end
   end

   assign stat.clear_last = (clr_ff == AW'(DEPTH - 1));
   assign stat.div_busy   = bx_busy | by_busy;

   assign rsp_color_out = color_out_ff;
   assign rsp_found     = found_ff;
   assign rsp_stored    = stored_ff;
endmodule

>>> rtl/cca_ctrl.sv
// Controller state machine: clearing pass, request intake, sequencing of the
// divide, check and memory steps, and the response valid flag. Uses cca_pkg.
`timescale 1ns / 1ps

module cca_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  cca_pkg::cca_stat_type stat,
   output cca_pkg::cca_cmd_type  cmd
);
   import cca_pkg::*;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_CALC  = 3'd3;
   localparam logic [2:0] ST_MEM   = 3'd4;
   localparam logic [2:0] ST_PUT   = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (!stat.div_busy) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = ST_MEM;
         end
         ST_MEM: begin
            cmd.mem_go = 1'b1;
            state_in   = ST_PUT;
         end
         ST_PUT: begin
            // The result register is loaded once the previous response has left.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.put  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.put) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

>>> rtl/cell_color_attribute_map.sv
// Top level of the cell colour attribute map: controller plus datapath.
// Depends on cca_pkg, cca_req_if, cca_rsp_if, cca_ctrl and cca_datapath.
//
//   Channel   Direction  Handshake      Contents
//   req_chan  in         valid/ready    opcode, px, py, color_in
//   rsp_chan  out        valid/ready    color_out, found, stored
//   csr_*     in         csr_we only    csr_index, csr_wdata
//
// Each accepted request runs through the two parallel radix-2 dividers that map the
// pixel to its cell, then the check, memory and result steps, before the next is accepted.
// After reset a clearing pass writes each of the MAX_CELL_COLS * MAX_CELL_ROWS cells (8192 at
// the defaults) as unset; no request is accepted meanwhile.
// A waiting response does not stop the next request being accepted; it only
// holds the following result back until it has been taken.
`timescale 1ns / 1ps

module cell_color_attribute_map #(
   parameter int MAX_CELL_COLS = 128,
   parameter int MAX_CELL_ROWS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   cca_req_if.sink                       req_chan,
   cca_rsp_if.source                     rsp_chan,
   input  logic                          csr_we,
   input  logic [cca_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cca_pkg::CSR_W-1:0]     csr_wdata
);
   import cca_pkg::*;

   cca_cmd_type  cmd;
   cca_stat_type stat;

   cca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   cca_datapath #(
      .COLS (MAX_CELL_COLS),
      .ROWS (MAX_CELL_ROWS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_opcode    (req_chan.opcode),
      .req_px        (req_chan.px),
      .req_py        (req_chan.py),
      .req_color_in  (req_chan.color_in),
      .rsp_color_out (rsp_chan.color_out),
      .rsp_found     (rsp_chan.found),
      .rsp_stored    (rsp_chan.stored)
   );

   // One request at a time: after an acceptance the block is busy.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("request accepted while the previous one was still in work");

   // A result is either a read or a write, never both.
   a_found_or_stored: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !(rsp_chan.found && rsp_chan.stored))
      else $error("response reports both found and stored");

   // A result that was not found carries a zero palette index.
   a_zero_when_missing: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.found |-> rsp_chan.color_out == '0)
      else $error("response without found carries a non-zero colour");

   // The divider never runs while requests are being taken.
   a_div_idle_at_intake: assert property (@(posedge clock) disable iff (reset)
      req_chan.ready |-> !stat.div_busy)
      else $error("divider busy while the block is ready for a request");
endmodule
